// File: hw/rtl/dis_pkg.sv
// Shared types and constants for the disjoint interval set.
// Holds the sequencer states, the command and status codes and the result record.
// Depends on nothing.
package dis_pkg;

    localparam int MAX_INTERVALS_DEF = 32;
    localparam int VALUE_BITS_DEF    = 16;
    localparam int FIELD_W           = 16;
    localparam int COUNT_W           = 6;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_DUMP = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHDN,
        S_SHUP,
        S_INS,
        S_DUMP,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        logic               last;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

// File: hw/rtl/dis_mem.sv
// Interval table storage: one write port and one read port with registered read data.
// Each word holds the low bound above the high bound. No package dependencies.
module dis_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/dis_seq.sv
// Sequencer for the interval table: scan for position, merge, shift and dump.
// Depends on dis_pkg and drives one dis_mem instance.
module dis_seq #(
    parameter int MAX_INTERVALS = dis_pkg::MAX_INTERVALS_DEF,
    parameter int VAL_W         = dis_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_cmd,
    input  logic [dis_pkg::FIELD_W-1:0]  i_value,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output dis_pkg::t_result             o_res
);
    import dis_pkg::*;

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int EW = 2 * VAL_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_n, n_n;
    logic [AW-1:0]     r_k, n_k;
    logic [CW-1:0]     r_i, n_i;
    logic [VAL_W-1:0]  r_v, n_v;
    logic [VAL_W-1:0]  r_prev_lo, n_prev_lo, r_prev_hi, n_prev_hi;
    logic [VAL_W-1:0]  r_cur_lo, n_cur_lo, r_cur_hi, n_cur_hi;
    t_result           r_res, n_res;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [EW-1:0]     mem_wdata, mem_rdata;
    logic [VAL_W-1:0]  rd_lo, rd_hi;

    logic [CW-1:0]     k_ext, k_next, i_m1, i_p1, n_m1, n_p1;
    logic [VAL_W:0]    prev_hi_p1, v_p1;
    logic              has_prev, has_cur, covered, touch_l, touch_r, dump_last;

    dis_mem #(
        .DEPTH (MAX_INTERVALS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    function automatic t_result mk_res(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
                                       input logic last, input t_status st,
                                       input logic [CW-1:0] cnt);
        t_result res;
        res.lo     = FIELD_W'(lo);
        res.hi     = FIELD_W'(hi);
        res.last   = last;
        res.status = st;
        res.count  = COUNT_W'(cnt);
        return res;
    endfunction

    assign rd_lo      = mem_rdata[EW-1:VAL_W];
    assign rd_hi      = mem_rdata[VAL_W-1:0];
    assign k_ext      = CW'(r_k);
    assign k_next     = k_ext + 1'b1;
    assign i_m1       = r_i - 1'b1;
    assign i_p1       = r_i + 1'b1;
    assign n_m1       = r_n - 1'b1;
    assign n_p1       = r_n + 1'b1;
    assign prev_hi_p1 = {1'b0, r_prev_hi} + 1'b1;
    assign v_p1       = {1'b0, r_v} + 1'b1;
    assign has_prev   = (r_i != '0);
    assign has_cur    = (r_i < r_n);
    assign covered    = has_prev && (r_prev_hi >= r_v);
    assign touch_l    = has_prev && (prev_hi_p1 == {1'b0, r_v});
    assign touch_r    = has_cur && (v_p1 == {1'b0, r_cur_lo});
    assign dump_last  = (k_next == r_n);

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_k       = r_k;
        n_i       = r_i;
        n_v       = r_v;
        n_prev_lo = r_prev_lo;
        n_prev_hi = r_prev_hi;
        n_cur_lo  = r_cur_lo;
        n_cur_hi  = r_cur_hi;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = r_res;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_v = i_value[VAL_W-1:0];
                    n_k = '0;
                    n_i = '0;
                    if (r_n == '0) begin
                        if (i_cmd == CMD_DUMP) begin
                            n_res   = mk_res('0, '0, 1'b1, STAT_EMPTY, '0);
                            n_state = S_RESULT;
                        end else begin
                            n_state = S_DECIDE;
                        end
                    end else begin
                        mem_re  = 1'b1;
                        n_state = (i_cmd == CMD_DUMP) ? S_DUMP : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // count the intervals that start at or below the value
                if (rd_lo <= r_v) begin
                    n_prev_lo = rd_lo;
                    n_prev_hi = rd_hi;
                    if (k_next == r_n) begin
                        n_i     = r_n;
                        n_state = S_DECIDE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = k_next[AW-1:0];
                        n_k       = k_next[AW-1:0];
                    end
                end else begin
                    n_cur_lo = rd_lo;
                    n_cur_hi = rd_hi;
                    n_i      = k_ext;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_RESULT;
                if (covered) begin
                    n_res = mk_res(r_prev_lo, r_prev_hi, 1'b1, STAT_OK, r_n);
                end else if (touch_l && touch_r) begin
                    // merge into the left neighbor, then close the gap
                    mem_we    = 1'b1;
                    mem_waddr = i_m1[AW-1:0];
                    mem_wdata = {r_prev_lo, r_cur_hi};
                    n_n       = n_m1;
                    n_res     = mk_res(r_prev_lo, r_cur_hi, 1'b1, STAT_OK, n_m1);
                    if (i_p1 < r_n) begin
                        mem_re    = 1'b1;
                        mem_raddr = i_p1[AW-1:0];
                        n_k       = i_p1[AW-1:0];
                        n_state   = S_SHDN;
                    end
                end else if (touch_l) begin
                    mem_we    = 1'b1;
                    mem_waddr = i_m1[AW-1:0];
                    mem_wdata = {r_prev_lo, r_v};
                    n_res     = mk_res(r_prev_lo, r_v, 1'b1, STAT_OK, r_n);
                end else if (touch_r) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_i[AW-1:0];
                    mem_wdata = {r_v, r_cur_hi};
                    n_res     = mk_res(r_v, r_cur_hi, 1'b1, STAT_OK, r_n);
                end else if (r_n == CW'(MAX_INTERVALS)) begin
                    n_res = mk_res('0, '0, 1'b1, STAT_FULL, r_n);
                end else begin
                    n_n   = n_p1;
                    n_res = mk_res(r_v, r_v, 1'b1, STAT_OK, n_p1);
                    if (r_n > r_i) begin
                        // open a slot: move the upper entries up, top first
                        mem_re    = 1'b1;
                        mem_raddr = n_m1[AW-1:0];
                        n_k       = n_m1[AW-1:0];
                        n_state   = S_SHUP;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_i[AW-1:0];
                        mem_wdata = {r_v, r_v};
                    end
                end
            end
            S_SHDN: begin
                mem_we    = 1'b1;
                mem_waddr = r_k - 1'b1;
                mem_wdata = mem_rdata;
                if (k_ext < r_n) begin
                    mem_re    = 1'b1;
                    mem_raddr = k_next[AW-1:0];
                    n_k       = k_next[AW-1:0];
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SHUP: begin
                mem_we    = 1'b1;
                mem_waddr = k_next[AW-1:0];
                mem_wdata = mem_rdata;
                if (k_ext > r_i) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_k - 1'b1;
                    n_k       = r_k - 1'b1;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[AW-1:0];
                mem_wdata = {r_v, r_v};
                n_state   = S_RESULT;
            end
            S_DUMP: begin
                o_res_valid = 1'b1;
                o_res       = mk_res(rd_lo, rd_hi, dump_last, STAT_OK, r_n);
                if (i_res_ready) begin
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = k_next[AW-1:0];
                        n_k       = k_next[AW-1:0];
                    end
                end
            end
            S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_i       <= n_i;
        r_v       <= n_v;
        r_prev_lo <= n_prev_lo;
        r_prev_hi <= n_prev_hi;
        r_cur_lo  <= n_cur_lo;
        r_cur_hi  <= n_cur_hi;
        r_res     <= n_res;
    end

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(MAX_INTERVALS))
        else $error("interval count exceeds table depth");

    a_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("table read and write at the same entry");

    a_dump_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && !i_res_ready) |=> (r_state == S_DUMP && $stable(r_k)))
        else $error("dump advanced while the result was stalled");

    a_shift_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHUP) |-> (k_ext < r_n && k_ext >= r_i))
        else $error("shift reads outside the occupied table");
`endif

endmodule

// File: hw/rtl/disjoint_interval_set.sv
// Disjoint interval set, top level: stream ports and the output register.
// Depends on dis_pkg, dis_seq and dis_mem.
//
// Usage: the slave channel takes one command item: tuser is the command
// (0 add the value in tdata, 1 dump the table). The master channel returns
// results: tdata carries the interval bounds and the entry count, tuser the
// status (ok, table full with value dropped, table empty) and tlast marks
// the final result of a command. An add yields one result; a dump yields one
// result per stored interval in ascending order, or one empty-status result.
// Sequence: an add reads one table entry per cycle up to the first interval
// that starts above the value (an add to an empty table reads none), then
// decides, moves the entries above when an interval is inserted or two are
// merged, writes an inserted interval that moved entries, and posts the
// result. A dump posts its first result once the first entry is read and
// one per cycle after that while the receiver takes them.
// The next command is taken the cycle after the previous one's last result
// has moved into the output register.
// A stalled receiver holds the output register and the sequencer; nothing is
// lost. Reset empties the table by clearing the entry count; the table needs
// no clearing pass.
module disjoint_interval_set #(
    parameter int MAX_INTERVALS = dis_pkg::MAX_INTERVALS_DEF,
    parameter int VALUE_BITS    = dis_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] value
    input  logic        i_s_axis_tuser,   // [0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [15:0] interval_low, [31:16] interval_high,
                                          // [37:32] entry_count, [39:38] zero
    output logic        o_m_axis_tlast,
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import dis_pkg::*;

    localparam int VAL_W = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;

    logic    res_valid, res_ready;
    t_result res;
    logic    r_ov;
    t_result r_out;

    dis_seq #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .VAL_W         (VAL_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_cmd       (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_ov || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_ready) begin
            r_ov <= res_valid;
        end
    end

    // load a new item whenever the register is free or being drained
    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {2'b00, r_out.count, r_out.hi, r_out.lo};
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tuser  = r_out.status;

endmodule
